[design/abcf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// abcf_pkg: shared types and constants of the alpha bounds collider fit
// Controller states, command and status groups, register indexes, job codes
// and the fixed widths of the arithmetic datapath.
// ----------------------------------------------------------------------------
package abcf_pkg;

    // field and register widths
    localparam int ALPHA_W   = 8;
    localparam int DIM_CFG_W = 13;
    localparam int CFG_W     = 32;
    localparam int IDX_W     = 3;
    localparam int Q_W       = 32;

    // arithmetic: 64-bit products, 16-bit multiplier chunks
    localparam int ACC_W     = 64;
    localparam int CHUNK_W   = 16;
    localparam int N_CHUNK   = 3;
    localparam int OPR_W     = CHUNK_W * N_CHUNK;
    localparam int CHK_IDX_W = 2;
    localparam int SQ_W      = 66;
    localparam int SQ_ITERS  = SQ_W / 2;
    localparam int ROOT_W    = SQ_ITERS;
    localparam int JOB_W     = 3;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_ALPHA_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SPRITE_WIDTH    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SPRITE_HEIGHT   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_PIVOT_X         = 3'd5;
    localparam logic [IDX_W-1:0] CFG_PIVOT_Y         = 3'd6;

    // divide jobs
    localparam logic [JOB_W-1:0] DIV_NCX = 3'd0;
    localparam logic [JOB_W-1:0] DIV_NCY = 3'd1;
    localparam logic [JOB_W-1:0] DIV_NSX = 3'd2;
    localparam logic [JOB_W-1:0] DIV_NSY = 3'd3;

    // multiply jobs
    localparam logic [JOB_W-1:0] JOB_CX  = 3'd0;
    localparam logic [JOB_W-1:0] JOB_CY  = 3'd1;
    localparam logic [JOB_W-1:0] JOB_RW  = 3'd2;
    localparam logic [JOB_W-1:0] JOB_RH  = 3'd3;
    localparam logic [JOB_W-1:0] JOB_RW2 = 3'd4;
    localparam logic [JOB_W-1:0] JOB_RH2 = 3'd5;

    typedef enum logic [3:0] {
        ST_SCAN,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_MUL,
        ST_MUL_STORE,
        ST_SQ_LOAD,
        ST_SQ_RUN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 scan;
        logic                 div_load;
        logic                 div_step;
        logic                 div_store;
        logic                 mul_step;
        logic                 mul_first;
        logic [CHK_IDX_W-1:0] chunk;
        logic                 mul_store;
        logic                 sq_load;
        logic                 sq_step;
        logic                 out_load;
        logic [JOB_W-1:0]     job;
    } cmd_t;

    typedef struct packed {
        logic accept_last;
        logic found_now;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

[design/abcf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// abcf_ctrl: frame sequencer
// Scans pixels, then for a frame with opaque pixels steps the datapath through
// four divides, six multiplies and a square root; every frame ends with the result load.
// ----------------------------------------------------------------------------
module abcf_ctrl #(
    parameter int NUMW = 30
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  abcf_pkg::status_t  status_i,
    output abcf_pkg::cmd_t     cmd_o
);
    import abcf_pkg::*;

    localparam int CNT_MAX = (NUMW > SQ_ITERS) ? NUMW : SQ_ITERS;
    localparam int CNTW    = $clog2(CNT_MAX);

    state_t            state_reg, state_next;
    logic [JOB_W-1:0]  job_reg, job_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SCAN;
            job_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_SCAN: begin
                if (status_i.accept_last) begin
                    job_next   = DIV_NCX;
                    state_next = status_i.found_now ? ST_DIV_LOAD : ST_OUT;
                end
            end
            ST_DIV_LOAD: begin
                cnt_next   = '0;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (cnt_reg == CNTW'(NUMW - 1)) begin
                    state_next = ST_DIV_STORE;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_DIV_STORE: begin
                if (job_reg == DIV_NSY) begin
                    job_next   = JOB_CX;
                    cnt_next   = CNTW'(N_CHUNK - 1);
                    state_next = ST_MUL;
                end else begin
                    job_next   = job_reg + JOB_W'(1);
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_MUL: begin
                if (cnt_reg == '0) begin
                    state_next = ST_MUL_STORE;
                end else begin
                    cnt_next = cnt_reg - CNTW'(1);
                end
            end
            ST_MUL_STORE: begin
                if (job_reg == JOB_RH2) begin
                    state_next = ST_SQ_LOAD;
                end else begin
                    job_next   = job_reg + JOB_W'(1);
                    cnt_next   = CNTW'(N_CHUNK - 1);
                    state_next = ST_MUL;
                end
            end
            ST_SQ_LOAD: begin
                cnt_next   = '0;
                state_next = ST_SQ_RUN;
            end
            ST_SQ_RUN: begin
                if (cnt_reg == CNTW'(SQ_ITERS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + CNTW'(1);
                end
            end
            ST_OUT: begin
                if (status_i.out_free) begin
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_SCAN;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd_o           = '0;
        cmd_o.job       = job_reg;
        cmd_o.chunk     = cnt_reg[CHK_IDX_W-1:0];
        cmd_o.mul_first = (cnt_reg == CNTW'(N_CHUNK - 1));
        unique case (state_reg)
            ST_SCAN:      cmd_o.scan      = 1'b1;
            ST_DIV_LOAD:  cmd_o.div_load  = 1'b1;
            ST_DIV_RUN:   cmd_o.div_step  = 1'b1;
            ST_DIV_STORE: cmd_o.div_store = 1'b1;
            ST_MUL:       cmd_o.mul_step  = 1'b1;
            ST_MUL_STORE: cmd_o.mul_store = 1'b1;
            ST_SQ_LOAD:   cmd_o.sq_load   = 1'b1;
            ST_SQ_RUN:    cmd_o.sq_step   = 1'b1;
            ST_OUT:       cmd_o.out_load  = status_i.out_free;
            default:      cmd_o.scan      = 1'b0;
        endcase
    end

`ifndef ASSERT_OFF
    // a result is never loaded over one still waiting
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.out_load |-> status_i.out_free)
        else $error("result loaded while output register busy");

    // a frame with opaque pixels starts the divide sequence
    a_frame_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_i.accept_last && status_i.found_now) |=> (state_reg == ST_DIV_LOAD))
        else $error("frame end did not start the fit");

    // multiplier chunk index stays in range
    a_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (cnt_reg < CNTW'(N_CHUNK)))
        else $error("multiplier chunk out of range");
`endif

endmodule
`default_nettype wire

[design/abcf_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// abcf_datapath: pixel scan, bounds and collider arithmetic
// Holds configuration, raster counters and bounds, a restoring divider, a
// chunked 16x48 multiplier, a digit-by-digit square root and the output word.
// ----------------------------------------------------------------------------
module abcf_datapath #(
    parameter int MAX_DIM = 4096
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  abcf_pkg::cmd_t                 cmd_i,
    output abcf_pkg::status_t              status_o,
    input  wire                            cfg_we,
    input  wire [abcf_pkg::IDX_W-1:0]      cfg_index,
    input  wire [abcf_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire                            s_valid,
    input  wire [abcf_pkg::ALPHA_W-1:0]    s_pixel_alpha,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic                           m_found,
    output logic signed [abcf_pkg::Q_W-1:0] m_center_x,
    output logic signed [abcf_pkg::Q_W-1:0] m_center_y,
    output logic signed [abcf_pkg::Q_W-1:0] m_size_x,
    output logic signed [abcf_pkg::Q_W-1:0] m_size_y,
    output logic [abcf_pkg::Q_W-1:0]       m_sphere_radius
);
    import abcf_pkg::*;

    localparam int CW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int RDW  = DW + 1;
    localparam int NUMW = CW + 18;
    localparam int QW   = CW + 17;
    localparam int DXW  = 36;

    // configuration
    logic [ALPHA_W-1:0]   thr_reg;
    logic [DIM_CFG_W-1:0] iw_reg, ih_reg;
    logic [Q_W-1:0]       sw_reg, sh_reg, px_reg, py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
            iw_reg  <= DIM_CFG_W'(64);
            ih_reg  <= DIM_CFG_W'(64);
            sw_reg  <= Q_W'(65536);
            sh_reg  <= Q_W'(65536);
            px_reg  <= Q_W'(32768);
            py_reg  <= Q_W'(32768);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ALPHA_THRESHOLD: thr_reg <= cfg_wdata[ALPHA_W-1:0];
                CFG_IMAGE_WIDTH:     iw_reg  <= cfg_wdata[DIM_CFG_W-1:0];
                CFG_IMAGE_HEIGHT:    ih_reg  <= cfg_wdata[DIM_CFG_W-1:0];
                CFG_SPRITE_WIDTH:    sw_reg  <= cfg_wdata;
                CFG_SPRITE_HEIGHT:   sh_reg  <= cfg_wdata;
                CFG_PIVOT_X:         px_reg  <= cfg_wdata;
                CFG_PIVOT_Y:         py_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp image size to 1..MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [DIM_CFG_W-1:0] d);
        logic [DW-1:0] r;
        if (d == '0) begin
            r = DW'(1);
        end else if (int'(d) > MAX_DIM) begin
            r = DW'(MAX_DIM);
        end else begin
            r = DW'(d);
        end
        return r;
    endfunction

    logic [DW-1:0] w, h;
    assign w = eff_dim(iw_reg);
    assign h = eff_dim(ih_reg);

    // raster counters and bounds
    logic [CW-1:0] column_reg, row_reg, minc_reg, maxc_reg, minr_reg, maxr_reg;
    logic          any_reg;
    logic [CW-1:0] nminc, nmaxc, nminr, nmaxr;
    logic          nany, opaque, accept, col_end, row_end, last;

    assign opaque  = s_pixel_alpha > thr_reg;
    assign accept  = cmd_i.scan && s_valid;
    assign col_end = (DW'(column_reg) + DW'(1)) >= w;
    assign row_end = (DW'(row_reg) + DW'(1)) >= h;
    assign last    = col_end && row_end;
    assign nminc   = (opaque && column_reg < minc_reg) ? column_reg : minc_reg;
    assign nmaxc   = (opaque && column_reg > maxc_reg) ? column_reg : maxc_reg;
    assign nminr   = (opaque && row_reg < minr_reg) ? row_reg : minr_reg;
    assign nmaxr   = (opaque && row_reg > maxr_reg) ? row_reg : maxr_reg;
    assign nany    = any_reg || opaque;

    logic [CW-1:0] cminc_reg, cmaxc_reg, cminr_reg, cmaxr_reg;
    logic          cfound_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
            minc_reg   <= CW'(MAX_DIM - 1);
            maxc_reg   <= '0;
            minr_reg   <= CW'(MAX_DIM - 1);
            maxr_reg   <= '0;
            any_reg    <= 1'b0;
        end else if (accept) begin
            if (col_end) begin
                column_reg <= '0;
                row_reg    <= row_end ? '0 : row_reg + CW'(1);
            end else begin
                column_reg <= column_reg + CW'(1);
            end
            if (last) begin
                minc_reg <= CW'(MAX_DIM - 1);
                maxc_reg <= '0;
                minr_reg <= CW'(MAX_DIM - 1);
                maxr_reg <= '0;
                any_reg  <= 1'b0;
            end else begin
                minc_reg <= nminc;
                maxc_reg <= nmaxc;
                minr_reg <= nminr;
                maxr_reg <= nmaxr;
                any_reg  <= nany;
            end
        end
    end

    // frame snapshot
    always_ff @(posedge aclk) begin
        if (accept && last) begin
            cminc_reg  <= nminc;
            cmaxc_reg  <= nmaxc;
            cminr_reg  <= nminr;
            cmaxr_reg  <= nmaxr;
            cfound_reg <= nany;
        end
    end

    assign status_o.accept_last = accept && last;
    assign status_o.found_now   = nany;
    assign status_o.out_free    = !m_valid || m_ready;

    // divider operands
    logic [NUMW-1:0] num_sel;
    logic [RDW-1:0]  den_sel;
    always_comb begin
        case (cmd_i.job)
            DIV_NCX: begin
                num_sel = ((NUMW'(cminc_reg) + NUMW'(cmaxc_reg) + NUMW'(1)) << 16) + NUMW'(w);
                den_sel = {w, 1'b0};
            end
            DIV_NCY: begin
                num_sel = ((NUMW'(cminr_reg) + NUMW'(cmaxr_reg) + NUMW'(1)) << 16) + NUMW'(h);
                den_sel = {h, 1'b0};
            end
            DIV_NSX: begin
                num_sel = ((NUMW'(cmaxc_reg - cminc_reg) + NUMW'(1)) << 17) + NUMW'(w);
                den_sel = {w, 1'b0};
            end
            default: begin
                num_sel = ((NUMW'(cmaxr_reg - cminr_reg) + NUMW'(1)) << 17) + NUMW'(h);
                den_sel = {h, 1'b0};
            end
        endcase
    end

    // restoring divider, one quotient bit a cycle
    logic [NUMW-1:0] num_reg;
    logic [RDW-1:0]  rem_reg, den_reg;
    logic [RDW:0]    rem_sh;
    logic            div_ge;
    logic [QW-1:0]   ncx_reg, ncy_reg, nsx_reg, nsy_reg;

    assign rem_sh = {rem_reg, num_reg[NUMW-1]};
    assign div_ge = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (cmd_i.div_load) begin
            num_reg <= num_sel;
            den_reg <= den_sel;
            rem_reg <= '0;
        end else if (cmd_i.div_step) begin
            rem_reg <= div_ge ? RDW'(rem_sh - {1'b0, den_reg}) : RDW'(rem_sh);
            num_reg <= {num_reg[NUMW-2:0], div_ge};
        end
        if (cmd_i.div_store) begin
            case (cmd_i.job)
                DIV_NCX: ncx_reg <= num_reg[QW-1:0];
                DIV_NCY: ncy_reg <= num_reg[QW-1:0];
                DIV_NSX: nsx_reg <= num_reg[QW-1:0];
                default: nsy_reg <= num_reg[QW-1:0];
            endcase
        end
    end

    // center offsets and magnitudes
    logic [DXW-1:0] dx, dy, mag_x, mag_y;
    assign dx    = {{(DXW-QW){1'b0}}, ncx_reg} - {{(DXW-Q_W){px_reg[Q_W-1]}}, px_reg};
    assign dy    = {{(DXW-Q_W){py_reg[Q_W-1]}}, py_reg} - {{(DXW-QW){1'b0}}, ncy_reg};
    assign mag_x = dx[DXW-1] ? (~dx + DXW'(1)) : dx;
    assign mag_y = dy[DXW-1] ? (~dy + DXW'(1)) : dy;

    // multiplier operands
    logic [OPR_W-1:0] rw_reg, rh_reg, mul_a, mul_b;
    always_comb begin
        case (cmd_i.job)
            JOB_CX: begin
                mul_a = {{(OPR_W-DXW){1'b0}}, mag_x};
                mul_b = {{(OPR_W-Q_W){1'b0}}, sw_reg};
            end
            JOB_CY: begin
                mul_a = {{(OPR_W-DXW){1'b0}}, mag_y};
                mul_b = {{(OPR_W-Q_W){1'b0}}, sh_reg};
            end
            JOB_RW: begin
                mul_a = {{(OPR_W-QW){1'b0}}, nsx_reg};
                mul_b = {{(OPR_W-Q_W){1'b0}}, sw_reg};
            end
            JOB_RH: begin
                mul_a = {{(OPR_W-QW){1'b0}}, nsy_reg};
                mul_b = {{(OPR_W-Q_W){1'b0}}, sh_reg};
            end
            JOB_RW2: begin
                mul_a = rw_reg;
                mul_b = rw_reg;
            end
            default: begin
                mul_a = rh_reg;
                mul_b = rh_reg;
            end
        endcase
    end

    // chunked multiply, high chunk first, 64-bit wrap as in a uint64 product
    logic [CHUNK_W-1:0] chunk_v;
    logic [ACC_W-1:0]   prod, acc_reg, rnd;
    logic [OPR_W-1:0]   qv;
    assign chunk_v = mul_a[CHUNK_W*cmd_i.chunk +: CHUNK_W];
    assign prod    = chunk_v * mul_b;
    assign rnd     = acc_reg + ACC_W'(32768);
    assign qv      = rnd[ACC_W-1:CHUNK_W];

    // signed saturation of a rounded magnitude
    function automatic logic [Q_W-1:0] sat_signed(input logic neg, input logic [OPR_W-1:0] q);
        logic [Q_W-1:0] r;
        if (neg) begin
            r = (q > OPR_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : (~q[Q_W-1:0] + Q_W'(1));
        end else begin
            r = (q > OPR_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[Q_W-1:0];
        end
        return r;
    endfunction

    logic [Q_W-1:0] cx_reg, cy_reg;
    logic [SQ_W-2:0] s_reg;

    always_ff @(posedge aclk) begin
        if (cmd_i.mul_step) begin
            acc_reg <= cmd_i.mul_first ? prod : ((acc_reg << CHUNK_W) + prod);
        end
        if (cmd_i.mul_store) begin
            case (cmd_i.job)
                JOB_CX:  cx_reg <= sat_signed(dx[DXW-1], qv);
                JOB_CY:  cy_reg <= sat_signed(dy[DXW-1], qv);
                JOB_RW:  rw_reg <= qv;
                JOB_RH:  rh_reg <= qv;
                JOB_RW2: s_reg  <= {1'b0, acc_reg};
                default: s_reg  <= s_reg + {1'b0, acc_reg};
            endcase
        end
    end

    // square root, two radicand bits a cycle
    logic [SQ_W-1:0]   sqv_reg;
    logic [ROOT_W:0]   srem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+2:0] srem_sh, trial;
    logic              sq_ge;
    assign srem_sh = {srem_reg, sqv_reg[SQ_W-1:SQ_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sq_ge   = srem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (cmd_i.sq_load) begin
            sqv_reg  <= {1'b0, s_reg};
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd_i.sq_step) begin
            srem_reg <= sq_ge ? (ROOT_W+1)'(srem_sh - trial) : (ROOT_W+1)'(srem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], sq_ge};
            sqv_reg  <= {sqv_reg[SQ_W-3:0], 2'b00};
        end
    end

    // radius and defaults
    logic [ROOT_W:0] rsum;
    logic [Q_W-1:0]  rad, mx, drad;
    logic [Q_W:0]    dsum;
    assign rsum = {1'b0, root_reg} + (ROOT_W+1)'(1);
    assign rad  = rsum[ROOT_W] ? 32'hFFFF_FFFF : rsum[Q_W:1];
    assign mx   = (sw_reg > sh_reg) ? sw_reg : sh_reg;
    assign dsum = {1'b0, mx} + (Q_W+1)'(1);
    assign drad = dsum[Q_W:1];

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd_i.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_found <= cfound_reg;
            if (cfound_reg) begin
                m_center_x      <= cx_reg;
                m_center_y      <= cy_reg;
                m_size_x        <= sat_signed(1'b0, rw_reg);
                m_size_y        <= sat_signed(1'b0, rh_reg);
                m_sphere_radius <= rad;
            end else begin
                m_center_x      <= '0;
                m_center_y      <= '0;
                m_size_x        <= sat_signed(1'b0, {{(OPR_W-Q_W){1'b0}}, sw_reg});
                m_size_y        <= sat_signed(1'b0, {{(OPR_W-Q_W){1'b0}}, sh_reg});
                m_sphere_radius <= drad;
            end
        end
    end

endmodule
`default_nettype wire

[design/alpha_bounds_collider_fit_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_bounds_collider_fit_top: opaque-region bounding box to collider fit
// Pixels of an image enter in raster order, one word a cycle. On the last
// pixel the block stops taking words while it fits the region and then
// delivers one result word. While scanning, one pixel is taken every cycle.
// After the last pixel of a frame with opaque pixels the fit runs four divides
// at one quotient bit a cycle, six multiplies of three 16-bit chunks and a
// 33-step square root, then waits for the output register to free; a frame
// with no opaque pixel goes straight to that wait. The next frame's pixels
// are taken once the result is loaded.
// ----------------------------------------------------------------------------
module alpha_bounds_collider_fit_top #(
    parameter int MAX_DIM = 4096
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_we,
    input  wire [abcf_pkg::IDX_W-1:0]       cfg_index,
    input  wire [abcf_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire [abcf_pkg::ALPHA_W-1:0]     s_pixel_alpha,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_found,
    output logic signed [abcf_pkg::Q_W-1:0] m_center_x,
    output logic signed [abcf_pkg::Q_W-1:0] m_center_y,
    output logic signed [abcf_pkg::Q_W-1:0] m_size_x,
    output logic signed [abcf_pkg::Q_W-1:0] m_size_y,
    output logic [abcf_pkg::Q_W-1:0]        m_sphere_radius
);
    import abcf_pkg::*;

    localparam int CW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NUMW = CW + 18;

    cmd_t    cmd;
    status_t status;

    assign s_ready = cmd.scan;

    // sequencer
    abcf_ctrl #(
        .NUMW (NUMW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status_i (status),
        .cmd_o    (cmd)
    );

    // arithmetic and storage
    abcf_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_i           (cmd),
        .status_o        (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_pixel_alpha   (s_pixel_alpha),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_center_x      (m_center_x),
        .m_center_y      (m_center_y),
        .m_size_x        (m_size_x),
        .m_size_y        (m_size_y),
        .m_sphere_radius (m_sphere_radius)
    );

endmodule
`default_nettype wire
